@@ rtl/md5md_pkg.sv @@
// ----------------------------------------------------------------------------
// md5md_pkg
// shared types, round constants and helpers for the md5 digest block
// ----------------------------------------------------------------------------
package md5md_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [5:0]  LenOffset = 6'd56;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       present;
    logic       last;
  } item_t;

  // front to back: head of the queue
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_ADD   = 4'b0100,
    ST_DONE  = 4'b1000
  } core_state_e;

  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_PAD1   = 2'd1,
    KIND_PAD2   = 2'd2
  } block_kind_e;

  function automatic logic [31:0] sine_k(input logic [5:0] j);
    logic [31:0] k;
    unique case (j)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  // rotate amount from round group and round mod 4
  function automatic logic [4:0] rot_amount(input logic [3:0] sel);
    logic [4:0] s;
    unique case (sel)
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/md5md_front.sv @@
// ----------------------------------------------------------------------------
// md5md_front
// takes input items, drops empty ones and queues the rest for the core
// ----------------------------------------------------------------------------
module md5md_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         msg_byte_i,
  input  logic               byte_present_i,
  input  logic               end_of_message_i,
  output md5md_pkg::head_t   head_o,
  input  logic               pop_i
);
  import md5md_pkg::*;

  item_t                  slot_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]     count_q, count_d;
  logic                   push, pop, full;

  assign full       = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign in_stall_o = full;
  // an item with neither byte nor end mark is taken and dropped
  assign push = in_valid_i && !full && (byte_present_i || end_of_message_i);
  assign pop  = pop_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{msg_byte: msg_byte_i, present: byte_present_i,
                            last: end_of_message_i};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QueuePtrW+1)'(QueueDepth))
    else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |=> (count_q <= 1))
    else $error("queue grew by more than one transfer");
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");
`endif

endmodule

@@ rtl/md5md_core.sv @@
// ----------------------------------------------------------------------------
// md5md_core
// block buffer, one-round-per-cycle compression, padding and digest output
// ----------------------------------------------------------------------------
module md5md_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  md5md_pkg::head_t  head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [63:0]       digest_first_half_o,
  output logic [63:0]       digest_second_half_o
);
  import md5md_pkg::*;

  core_state_e  state_q, state_d;
  block_kind_e  kind_q, kind_d;
  logic [5:0]   round_q, round_d;
  logic [5:0]   fill_q, fill_d;
  logic [63:0]  count_q, count_d;
  logic         last_pend_q, last_pend_d;
  logic [31:0]  chain_q [4];
  logic [31:0]  chain_d [4];
  logic [31:0]  words_q [4];
  logic [31:0]  words_d [4];
  logic [31:0]  sum [4];
  logic [31:0]  block_q [16];
  logic         out_valid_q, out_valid_d;
  logic [63:0]  first_q, second_q;
  logic         load_out, wr_byte;

  // round datapath
  logic [3:0]   jl, idx;
  logic [31:0]  mix, raw, w, t;
  logic [63:0]  rot_wide;
  logic [5:0]   pos;
  logic         len_word;

  assign jl = round_q[3:0];

  always_comb begin
    unique case (round_q[5:4])
      2'd0: begin
        mix = (words_q[1] & words_q[2]) | (~words_q[1] & words_q[3]);
        idx = jl;
      end
      2'd1: begin
        mix = (words_q[3] & words_q[1]) | (~words_q[3] & words_q[2]);
        idx = 4'(jl * 4'd5 + 4'd1);
      end
      2'd2: begin
        mix = words_q[1] ^ words_q[2] ^ words_q[3];
        idx = 4'(jl * 4'd3 + 4'd5);
      end
      default: begin
        mix = words_q[2] ^ (words_q[1] | ~words_q[3]);
        idx = 4'(jl * 4'd7);
      end
    endcase
  end

  // padded view of the block word
  always_comb begin
    raw = block_q[idx];
    w   = raw;
    for (int l = 0; l < 4; l++) begin
      pos = {idx, 2'(l)};
      unique case (kind_q)
        KIND_NORMAL: w[8*l +: 8] = raw[8*l +: 8];
        KIND_PAD1: begin
          if (pos < fill_q) begin
            w[8*l +: 8] = raw[8*l +: 8];
          end else if (pos == fill_q) begin
            w[8*l +: 8] = PadByte;
          end else begin
            w[8*l +: 8] = '0;
          end
        end
        default: w[8*l +: 8] = '0;
      endcase
    end
    len_word = (kind_q == KIND_PAD2) || ((kind_q == KIND_PAD1) && (fill_q < LenOffset));
    if (len_word && (idx >= 4'(LenOffset >> 2))) begin
      w = idx[0] ? count_q[63:32] : count_q[31:0];
    end
  end

  assign t        = mix + words_q[0] + sine_k(round_q) + w;
  assign rot_wide = {t, t} << rot_amount({round_q[5:4], round_q[1:0]});

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum[i] = chain_q[i] + words_q[i];
    end
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    round_d     = round_q;
    fill_d      = fill_q;
    count_d     = count_q;
    last_pend_d = last_pend_q;
    chain_d     = chain_q;
    words_d     = words_q;
    pop_o       = 1'b0;
    wr_byte     = 1'b0;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          if (head_i.item.present) begin
            wr_byte = 1'b1;
            fill_d  = fill_q + 1'b1;
            count_d = count_q + 64'd8;
          end
          if (head_i.item.present && (fill_q == 6'd63)) begin
            kind_d      = KIND_NORMAL;
            last_pend_d = head_i.item.last;
            words_d     = chain_q;
            state_d     = ST_ROUND;
          end else if (head_i.item.last) begin
            kind_d  = KIND_PAD1;
            words_d = chain_q;
            state_d = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        words_d[0] = words_q[3];
        words_d[3] = words_q[2];
        words_d[2] = words_q[1];
        words_d[1] = words_q[1] + rot_wide[63:32];
        round_d    = round_q + 1'b1;
        if (round_q == 6'd63) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        chain_d = sum;
        unique case (kind_q)
          KIND_NORMAL: begin
            fill_d = '0;
            if (last_pend_q) begin
              last_pend_d = 1'b0;
              kind_d      = KIND_PAD1;
              words_d     = sum;
              state_d     = ST_ROUND;
            end else begin
              state_d = ST_IDLE;
            end
          end
          KIND_PAD1: begin
            if (fill_q >= LenOffset) begin
              kind_d  = KIND_PAD2;
              words_d = sum;
              state_d = ST_ROUND;
            end else begin
              state_d = ST_DONE;
            end
          end
          default: state_d = ST_DONE;
        endcase
      end
      default: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          chain_d     = '{InitA, InitB, InitC, InitD};
          fill_d      = '0;
          count_d     = '0;
          kind_d      = KIND_NORMAL;
          state_d     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= KIND_NORMAL;
      round_q     <= '0;
      fill_q      <= '0;
      count_q     <= '0;
      last_pend_q <= 1'b0;
      chain_q     <= '{InitA, InitB, InitC, InitD};
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      round_q     <= round_d;
      fill_q      <= fill_d;
      count_q     <= count_d;
      last_pend_q <= last_pend_d;
      chain_q     <= chain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    words_q <= words_d;
    if (wr_byte) begin
      block_q[fill_q[5:2]][8*fill_q[1:0] +: 8] <= head_i.item.msg_byte;
    end
    if (load_out) begin
      first_q  <= {chain_q[1], chain_q[0]};
      second_q <= {chain_q[3], chain_q[2]};
    end
  end

  assign out_valid_o          = out_valid_q;
  assign digest_first_half_o  = first_q;
  assign digest_second_half_o = second_q;

`ifndef NO_ASSERTIONS
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && round_q == 6'd63) |=> (state_q == ST_ADD))
    else $error("round 63 not followed by chain update");
  a_done_padded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (kind_q != KIND_NORMAL))
    else $error("digest after a plain block");
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("digest shown without finishing");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_IDLE && head_i.valid))
    else $error("queue popped while busy");
`endif

endmodule

@@ rtl/md5_message_digest_top.sv @@
// a byte is taken by the core while it is idle; a full 64-byte block then adds compression
// (64 rounds at one round per cycle through the round adder, then a chain update)
// message end: 1 or 2 padded blocks, then the done state loads the output register
// the core takes no new byte until a full block's rounds and chain update are through,
// and the queue stalls the input once full
// reset: asynchronous, active low; chain value takes the initial words, queue empties
// ----------------------------------------------------------------------------
// md5_message_digest_top
// streaming md5 digest: byte queue in front, compression core behind
// ----------------------------------------------------------------------------
module md5_message_digest_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  msg_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] digest_first_half_o,
  output logic [63:0] digest_second_half_o
);
  import md5md_pkg::*;

  head_t head;
  logic  pop;

  md5md_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .msg_byte_i,
    .byte_present_i,
    .end_of_message_i,
    .head_o (head),
    .pop_i  (pop)
  );

  md5md_core u_core (
    .clk_i,
    .rst_ni,
    .head_i (head),
    .pop_o  (pop),
    .out_valid_o,
    .out_stall_i,
    .digest_first_half_o,
    .digest_second_half_o
  );

endmodule
